FILE: hw/rtl/tccp_pkg.sv
// Shared types and constants of the text console character placer.
package tccp_pkg;

  // Default geometry of the history ring.
  localparam int unsigned HISTORY_LINES_DEF = 64;
  localparam int unsigned STORE_COLUMNS_DEF = 128;

  // Control characters that get special treatment.
  localparam logic [7:0] CODE_CR = 8'h0D;
  localparam logic [7:0] CODE_LF = 8'h0A;

  // Register reset values.
  localparam logic [7:0]  RESET_COLS = 8'd80;
  localparam logic [6:0]  RESET_ROWS = 7'd25;
  localparam logic [31:0] RESET_FG   = 32'h00FF_FFFF;
  localparam logic [31:0] RESET_BG   = 32'h0000_00FF;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_FG      = 2'd2,
    REG_BG      = 2'd3
  } cfg_reg_e;

  // One stored console cell.
  typedef struct packed {
    logic [7:0]  chr;
    logic [31:0] fg;
    logic [31:0] bg;
  } cell_t;

endpackage

FILE: hw/rtl/tccp_cell_mem.sv
// Cell memory of the console: one write port, one read port with registered data.
module tccp_cell_mem #(
  parameter int unsigned HISTORY_LINES = tccp_pkg::HISTORY_LINES_DEF,
  parameter int unsigned STORE_COLUMNS = tccp_pkg::STORE_COLUMNS_DEF,
  localparam int unsigned LW = $clog2(HISTORY_LINES),
  localparam int unsigned CAW = $clog2(STORE_COLUMNS),
  localparam int unsigned AW = LW + CAW
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  tccp_pkg::cell_t wr_cell_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output tccp_pkg::cell_t rd_cell_o
);
  import tccp_pkg::*;

  // Lines are laid out on a power-of-two column pitch.
  localparam int unsigned DEPTH = HISTORY_LINES * (2 ** CAW);

  cell_t mem_q [DEPTH];
  cell_t rd_cell_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_cell_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_cell_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_cell_o = rd_cell_q;

endmodule

FILE: hw/rtl/text_console_char_placer.sv
// Text console character placer. The console cells (character byte plus
// foreground and background colour) live in one synchronous memory that holds
// a ring of HISTORY_LINES lines, each on a pitch of STORE_COLUMNS rounded up to
// a power of two. A put beat places one character at the cursor and advances
// it; carriage return does nothing, newline moves to column 0 of the next row,
// and running past the last visible row scrolls the view by one line and blanks
// the new bottom line in the current colours. A read beat returns one cell,
// addressed relative to the view start. After reset the block first sweeps the
// whole memory to the reset cell contents, one entry per cycle, which covers
// HISTORY_LINES * 2**ceil(log2(STORE_COLUMNS)) entries (8192 at the defaults);
// no input beat is taken during the sweep, while configuration writes are. Items
// are handled one at a time by a small sequencer around the single memory write
// port. A read issues the memory read on acceptance, then loads the result. A
// carriage return goes straight to the result; a newline moves the cursor, then
// checks for a scroll. An ordinary character passes a cursor check, a row check
// when a narrowed width first wraps the cursor, the write and a scroll check. Each
// scroll clears the new bottom line one cell per cycle through the write port; a
// put can scroll at most twice. The next item is accepted as soon as the result
// sits in the output register, even if it has not been taken.
// Configuration should be written only while no item is in flight.
module text_console_char_placer #(
  parameter int unsigned HISTORY_LINES = tccp_pkg::HISTORY_LINES_DEF,
  parameter int unsigned STORE_COLUMNS = tccp_pkg::STORE_COLUMNS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Request channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [5:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        cell_written_o,
  output logic [5:0]  write_line_o,
  output logic [6:0]  write_col_o,
  output logic [6:0]  cursor_col_o,
  output logic [5:0]  cursor_row_o,
  output logic [5:0]  view_start_o,
  output logic        scrolled_o,
  output logic [7:0]  read_char_o,
  output logic [31:0] read_fg_o,
  output logic [31:0] read_bg_o,
  output logic [31:0] scroll_total_o
);
  import tccp_pkg::*;

  // Line index, stored column index, and counts that must also hold the maxima.
  localparam int unsigned LW = $clog2(HISTORY_LINES);
  localparam int unsigned CAW = $clog2(STORE_COLUMNS);
  localparam int unsigned AW = LW + CAW;
  localparam int unsigned CNW = $clog2(STORE_COLUMNS + 1);
  localparam int unsigned RNW = $clog2(HISTORY_LINES + 1);
  localparam int unsigned DEPTH = HISTORY_LINES * (2 ** CAW);
  localparam int unsigned ROW_SPAN = 64;

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_PRE   = 8'b0000_0100,
    ST_CHK   = 8'b0000_1000,
    ST_WRITE = 8'b0001_0000,
    ST_FIN   = 8'b0010_0000,
    ST_CLEAR = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  // Configuration registers.
  logic [7:0]  cols_cfg_q;
  logic [6:0]  rows_cfg_q;
  logic [31:0] fg_q;
  logic [31:0] bg_q;

  // Console state.
  logic [CNW-1:0] col_q, col_d;
  logic [RNW-1:0] line_q, line_d;
  logic [LW-1:0]  view_q, view_d;
  logic [31:0]    scroll_cnt_q, scroll_cnt_d;

  // Sweep counters.
  logic [AW-1:0]  init_addr_q, init_addr_d;
  logic [LW-1:0]  clr_line_q, clr_line_d;
  logic [CNW-1:0] clr_col_q, clr_col_d;

  // Per-item working registers.
  logic [7:0]     code_q, code_d;
  logic           is_read_q, is_read_d;
  logic           rd_ok_q, rd_ok_d;
  logic           written_q, written_d;
  logic [LW-1:0]  wline_q, wline_d;
  logic [CAW-1:0] wcol_q, wcol_d;
  logic           scrolled_q, scrolled_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic        o_written_q;
  logic [5:0]  o_wline_q;
  logic [6:0]  o_wcol_q;
  logic [6:0]  o_ccol_q;
  logic [5:0]  o_crow_q;
  logic [5:0]  o_view_q;
  logic        o_scrolled_q;
  logic [7:0]  o_char_q;
  logic [31:0] o_fg_q;
  logic [31:0] o_bg_q;
  logic [31:0] o_total_q;

  // Effective geometry after clamping the registers.
  logic [CNW-1:0] cols_eff;
  logic [RNW-1:0] rows_eff;

  always_comb begin
    if (cols_cfg_q == 8'd0) begin
      cols_eff = CNW'(1);
    end else if (32'(cols_cfg_q) > 32'(STORE_COLUMNS)) begin
      cols_eff = CNW'(STORE_COLUMNS);
    end else begin
      cols_eff = CNW'(cols_cfg_q);
    end
    if (rows_cfg_q == 7'd0) begin
      rows_eff = RNW'(1);
    end else if (32'(rows_cfg_q) > 32'(HISTORY_LINES)) begin
      rows_eff = RNW'(HISTORY_LINES);
    end else begin
      rows_eff = RNW'(rows_cfg_q);
    end
  end

  logic line_past;
  logic col_past;
  assign line_past = (line_q >= rows_eff);
  assign col_past  = (col_q >= cols_eff);

  // Read row folded into the ring: a constant table gives read_row mod the ring
  // size, then one compare and subtract adds the view start.
  logic [LW-1:0] row_mod [ROW_SPAN];
  for (genvar g = 0; g < ROW_SPAN; g++) begin : g_row_mod
    assign row_mod[g] = LW'(g % HISTORY_LINES);
  end

  logic [LW:0]   rsum;
  logic [LW-1:0] rd_line;
  logic          rd_col_ok;
  assign rsum = {1'b0, view_q} + {1'b0, row_mod[read_row_i]};
  assign rd_line = (rsum >= (LW+1)'(HISTORY_LINES)) ?
                   LW'(rsum - (LW+1)'(HISTORY_LINES)) : LW'(rsum);
  assign rd_col_ok = (32'(read_col_i) < 32'(STORE_COLUMNS));

  // History line under the cursor; the cursor row is below the ring size here.
  logic [LW:0]   wsum;
  logic [LW-1:0] cur_line;
  assign wsum = {1'b0, view_q} + (LW+1)'(line_q);
  assign cur_line = (wsum >= (LW+1)'(HISTORY_LINES)) ?
                    LW'(wsum - (LW+1)'(HISTORY_LINES)) : LW'(wsum);

  // View start and bottom line after one scroll.
  logic [LW-1:0] view_inc;
  logic [LW:0]   bsum;
  logic [LW-1:0] blank_line;
  assign view_inc = (view_q == LW'(HISTORY_LINES - 1)) ? '0 : view_q + LW'(1);
  assign bsum = {1'b0, view_inc} + (LW+1)'(rows_eff - RNW'(1));
  assign blank_line = (bsum >= (LW+1)'(HISTORY_LINES)) ?
                      LW'(bsum - (LW+1)'(HISTORY_LINES)) : LW'(bsum);

  // Memory ports.
  logic    mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t   mem_wcell;
  logic    mem_re;
  logic [AW-1:0] mem_raddr;
  cell_t   mem_rcell;

  logic in_accept;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign mem_re    = in_accept & req_type_i;
  assign mem_raddr = {rd_line, CAW'(read_col_i)};

  logic [CNW-1:0] col_inc;
  logic           do_scroll;
  state_e         scroll_ret;
  assign col_inc = col_q + CNW'(1);

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    col_d        = col_q;
    line_d       = line_q;
    view_d       = view_q;
    scroll_cnt_d = scroll_cnt_q;
    init_addr_d  = init_addr_q;
    clr_line_d   = clr_line_q;
    clr_col_d    = clr_col_q;
    code_d       = code_q;
    is_read_d    = is_read_q;
    rd_ok_d      = rd_ok_q;
    written_d    = written_q;
    wline_d      = wline_q;
    wcol_d       = wcol_q;
    scrolled_d   = scrolled_q;
    out_load     = 1'b0;
    do_scroll    = 1'b0;
    scroll_ret   = ST_DONE;
    mem_we       = 1'b0;
    mem_waddr    = init_addr_q;
    mem_wcell    = '{chr: 8'd0, fg: RESET_FG, bg: RESET_BG};

    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        if (init_addr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          init_addr_d = init_addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          code_d     = char_code_i;
          is_read_d  = req_type_i;
          rd_ok_d    = req_type_i & rd_col_ok;
          written_d  = 1'b0;
          wline_d    = '0;
          wcol_d     = '0;
          scrolled_d = 1'b0;
          if (req_type_i || char_code_i == CODE_CR) begin
            state_d = ST_DONE;
          end else if (char_code_i == CODE_LF) begin
            col_d   = '0;
            line_d  = line_q + RNW'(1);
            state_d = ST_FIN;
          end else begin
            state_d = ST_PRE;
          end
        end
      end
      ST_PRE: begin
        // A cursor left outside the area by a register change is pulled back.
        if (line_past) begin
          do_scroll  = 1'b1;
          scroll_ret = ST_WRITE;
        end else if (col_past) begin
          col_d   = '0;
          line_d  = line_q + RNW'(1);
          state_d = ST_CHK;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_CHK: begin
        if (line_past) begin
          do_scroll  = 1'b1;
          scroll_ret = ST_WRITE;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = {cur_line, col_q[CAW-1:0]};
        mem_wcell = '{chr: code_q, fg: fg_q, bg: bg_q};
        written_d = 1'b1;
        wline_d   = cur_line;
        wcol_d    = col_q[CAW-1:0];
        if (col_inc >= cols_eff) begin
          col_d  = '0;
          line_d = line_q + RNW'(1);
        end else begin
          col_d = col_inc;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (line_past) begin
          do_scroll  = 1'b1;
          scroll_ret = ST_DONE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {clr_line_q, clr_col_q[CAW-1:0]};
        mem_wcell = '{chr: 8'd0, fg: fg_q, bg: bg_q};
        if (clr_col_q == cols_eff - CNW'(1)) begin
          state_d = ret_q;
        end else begin
          clr_col_d = clr_col_q + CNW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Scroll by one line, then blank the new bottom line cell by cell.
    if (do_scroll) begin
      scroll_cnt_d = scroll_cnt_q + 32'd1;
      view_d       = view_inc;
      clr_line_d   = blank_line;
      clr_col_d    = '0;
      line_d       = rows_eff - RNW'(1);
      if (col_past) begin
        col_d = '0;
      end
      scrolled_d = 1'b1;
      ret_d      = scroll_ret;
      state_d    = ST_CLEAR;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      ret_q        <= ST_DONE;
      col_q        <= '0;
      line_q       <= '0;
      view_q       <= '0;
      scroll_cnt_q <= '0;
      init_addr_q  <= '0;
      out_valid_q  <= 1'b0;
      cols_cfg_q   <= RESET_COLS;
      rows_cfg_q   <= RESET_ROWS;
      fg_q         <= RESET_FG;
      bg_q         <= RESET_BG;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      col_q        <= col_d;
      line_q       <= line_d;
      view_q       <= view_d;
      scroll_cnt_q <= scroll_cnt_d;
      init_addr_q  <= init_addr_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_COLUMNS: cols_cfg_q <= cfg_data_i[7:0];
          REG_ROWS:    rows_cfg_q <= cfg_data_i[6:0];
          REG_FG:      fg_q       <= cfg_data_i;
          REG_BG:      bg_q       <= cfg_data_i;
          default:     cols_cfg_q <= cols_cfg_q;
        endcase
      end
    end
  end

  // Per-item working registers and the result register.
  always_ff @(posedge clk_i) begin
    clr_line_q <= clr_line_d;
    clr_col_q  <= clr_col_d;
    code_q     <= code_d;
    is_read_q  <= is_read_d;
    rd_ok_q    <= rd_ok_d;
    written_q  <= written_d;
    wline_q    <= wline_d;
    wcol_q     <= wcol_d;
    scrolled_q <= scrolled_d;
    if (out_load) begin
      o_written_q  <= written_q;
      o_wline_q    <= 6'(wline_q);
      o_wcol_q     <= 7'(wcol_q);
      o_ccol_q     <= 7'(col_q);
      o_crow_q     <= 6'(line_q);
      o_view_q     <= 6'(view_q);
      o_scrolled_q <= scrolled_q;
      o_total_q    <= scroll_cnt_q;
      if (is_read_q && rd_ok_q) begin
        o_char_q <= mem_rcell.chr;
        o_fg_q   <= mem_rcell.fg;
        o_bg_q   <= mem_rcell.bg;
      end else begin
        o_char_q <= 8'd0;
        o_fg_q   <= 32'd0;
        o_bg_q   <= 32'd0;
      end
    end
  end

  tccp_cell_mem #(
    .HISTORY_LINES(HISTORY_LINES),
    .STORE_COLUMNS(STORE_COLUMNS)
  ) u_cell_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_cell_i (mem_wcell),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_cell_o (mem_rcell)
  );

  assign out_valid_o    = out_valid_q;
  assign cell_written_o = o_written_q;
  assign write_line_o   = o_wline_q;
  assign write_col_o    = o_wcol_q;
  assign cursor_col_o   = o_ccol_q;
  assign cursor_row_o   = o_crow_q;
  assign view_start_o   = o_view_q;
  assign scrolled_o     = o_scrolled_q;
  assign read_char_o    = o_char_q;
  assign read_fg_o      = o_fg_q;
  assign read_bg_o      = o_bg_q;
  assign scroll_total_o = o_total_q;

endmodule
